// ===== rtl/bsd_pkg.sv =====
`default_nettype none
package bsd_pkg;

  localparam int COORD_W  = 32;
  localparam int HALF_W   = 31;
  localparam int DIFF_W   = COORD_W + 1;
  localparam int Q_W      = COORD_W + 2;
  localparam int COMP_W   = COORD_W - 1;
  localparam int SQ_W     = 2 * COMP_W;
  localparam int SUM_W    = 2 * COORD_W;
  localparam int ROOT_W   = SUM_W / 2;
  localparam int REM_W    = ROOT_W + 2;
  localparam int SQRT_STEPS = ROOT_W;

  localparam logic [COORD_W-1:0] SAT_MAX = {1'b0, {(COORD_W-1){1'b1}}};

  // sideband that rides along the root pipeline
  typedef struct packed {
    logic               in_box;
    logic               big;
    logic [COORD_W-1:0] near;
  } side_t;

endpackage
`default_nettype wire

// ===== rtl/bsd_in_if.sv =====
`default_nettype none
interface bsd_in_if;
  import bsd_pkg::*;

  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] point_x;
  logic [COORD_W-1:0] point_y;
  logic [COORD_W-1:0] point_z;
  logic [COORD_W-1:0] center_x;
  logic [COORD_W-1:0] center_y;
  logic [COORD_W-1:0] center_z;
  logic [HALF_W-1:0]  half_x;
  logic [HALF_W-1:0]  half_y;
  logic [HALF_W-1:0]  half_z;

  modport source (
    output valid, point_x, point_y, point_z, center_x, center_y, center_z,
           half_x, half_y, half_z,
    input  ready
  );
  modport sink (
    input  valid, point_x, point_y, point_z, center_x, center_y, center_z,
           half_x, half_y, half_z,
    output ready
  );
endinterface
`default_nettype wire

// ===== rtl/bsd_out_if.sv =====
`default_nettype none
interface bsd_out_if;
  import bsd_pkg::*;

  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] distance;

  modport source (output valid, distance, input ready);
  modport sink (input valid, distance, output ready);
endinterface
`default_nettype wire

// ===== rtl/bsd_front.sv =====
`default_nettype none
module bsd_front
  import bsd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  bsd_in_if.sink                  query,
  output logic                    valid,
  output logic [SUM_W-1:0]        sum,
  output side_t                   side
);

  logic                      v1, v2, v3, v4, v5;
  logic signed [DIFF_W-1:0]  d1 [3];
  logic        [HALF_W-1:0]  h1 [3];
  logic        [DIFF_W-1:0]  a2 [3];
  logic        [HALF_W-1:0]  h2 [3];
  logic signed [Q_W-1:0]     q3 [3];
  logic        [COMP_W-1:0]  c4 [3];
  side_t                     s4, s5;
  logic        [SQ_W-1:0]    sq5 [3];

  logic signed [Q_W-1:0]     qmax;
  logic                      pos [3];
  logic                      over [3];
  logic        [COORD_W-1:0] px [3];
  logic        [COORD_W-1:0] cx [3];
  logic        [HALF_W-1:0]  hx [3];

  assign px[0] = query.point_x;
  assign px[1] = query.point_y;
  assign px[2] = query.point_z;
  assign cx[0] = query.center_x;
  assign cx[1] = query.center_y;
  assign cx[2] = query.center_z;
  assign hx[0] = query.half_x;
  assign hx[1] = query.half_y;
  assign hx[2] = query.half_z;

  assign query.ready = en;

  // largest axis term and per axis clamp
  always_comb begin
    qmax = q3[0];
    if (q3[1] > qmax) qmax = q3[1];
    if (q3[2] > qmax) qmax = q3[2];
    for (int i = 0; i < 3; i++) begin
      pos[i]  = !q3[i][Q_W-1] && (q3[i] != '0);
      over[i] = pos[i] && (q3[i][Q_W-2:COMP_W] != '0);
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      valid <= 1'b0;
    end else if (en) begin
      v1 <= query.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      valid <= v5;
    end
  end

  // data stages: difference, magnitude, offset, clamp, square, sum
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        d1[i] <= $signed({px[i][COORD_W-1], px[i]}) - $signed({cx[i][COORD_W-1], cx[i]});
        h1[i] <= hx[i];
        a2[i] <= d1[i][DIFF_W-1] ? DIFF_W'(-d1[i]) : DIFF_W'(d1[i]);
        h2[i] <= h1[i];
        q3[i] <= $signed({1'b0, a2[i]}) - $signed({{(Q_W-HALF_W){1'b0}}, h2[i]});
        c4[i] <= (pos[i] && !over[i]) ? q3[i][COMP_W-1:0] : '0;
        sq5[i] <= c4[i] * c4[i];
      end
      s4.in_box <= qmax[Q_W-1] || (qmax == '0);
      s4.big    <= over[0] || over[1] || over[2];
      s4.near   <= qmax[COORD_W-1:0];
      s5  <= s4;
      side <= s5;
      sum <= {{(SUM_W-SQ_W){1'b0}}, sq5[0]} + {{(SUM_W-SQ_W){1'b0}}, sq5[1]}
           + {{(SUM_W-SQ_W){1'b0}}, sq5[2]};
    end
  end

endmodule
`default_nettype wire

// ===== rtl/bsd_sqrt.sv =====
`default_nettype none
module bsd_sqrt
  import bsd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [SUM_W-1:0]  in_x,
  input  side_t                  in_side,
  output logic                   valid,
  output logic [ROOT_W-1:0]      root,
  output side_t                  side
);

  logic              v  [SQRT_STEPS];
  logic [SUM_W-1:0]  xs [SQRT_STEPS];
  logic [REM_W-1:0]  rm [SQRT_STEPS];
  logic [ROOT_W-1:0] rt [SQRT_STEPS];
  side_t             sd [SQRT_STEPS];

  // one result bit per stage, most significant first
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    logic              pv;
    logic [SUM_W-1:0]  px;
    logic [REM_W-1:0]  prem;
    logic [ROOT_W-1:0] proot;
    side_t             pside;
    logic [REM_W+1:0]  shifted;
    logic [REM_W+1:0]  trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign pv    = in_valid;
      assign px    = in_x;
      assign prem  = '0;
      assign proot = '0;
      assign pside = in_side;
    end else begin : g_rest
      assign pv    = v[k-1];
      assign px    = xs[k-1];
      assign prem  = rm[k-1];
      assign proot = rt[k-1];
      assign pside = sd[k-1];
    end

    assign shifted = {prem, px[SUM_W-1-2*k -: 2]};
    assign trial   = {{(REM_W+2-ROOT_W-2){1'b0}}, proot, 2'b01};
    assign ge      = shifted >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en) begin
        v[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        xs[k] <= px;
        sd[k] <= pside;
        rm[k] <= ge ? REM_W'(shifted - trial) : REM_W'(shifted);
        rt[k] <= {proot[ROOT_W-2:0], ge};
      end
    end
  end

  assign valid = v[SQRT_STEPS-1];
  assign root  = rt[SQRT_STEPS-1];
  assign side  = sd[SQRT_STEPS-1];

endmodule
`default_nettype wire

// ===== rtl/bsd_skid.sv =====
`default_nettype none
module bsd_skid
  import bsd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic [COORD_W-1:0] in_data,
  output logic                    en,
  bsd_out_if.source               result
);

  logic               full;
  logic [COORD_W-1:0] hold_data;

  assign en              = !full;
  assign result.valid    = full || in_valid;
  assign result.distance = full ? hold_data : in_data;

  // park the last stage item when the sink stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (!full && in_valid && !result.ready) begin
      full <= 1'b1;
    end else if (full && result.ready) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!full && in_valid && !result.ready) begin
      hold_data <= in_data;
    end
  end

  a_full_shown: assert property (@(posedge clk) disable iff (rst)
    full |-> result.valid && (result.distance == hold_data))
    else $error("parked item not presented");

  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    (full && !result.ready) |=> full && $stable(hold_data))
    else $error("parked item lost under stall");

endmodule
`default_nettype wire

// ===== rtl/box_signed_distance_top.sv =====
`default_nettype none
// pipeline: 6 front stages, then 32 root stages, from item accept to result valid
// throughput: one item per cycle while the output does not stall, set by the one-bit-per-stage square root pipeline
// an output stall parks one item in the skid register
// reset (rst, synchronous) clears all valid bits and the skid full flag
module box_signed_distance_top
  import bsd_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  bsd_in_if.sink      query,
  bsd_out_if.source   result
);

  logic               en;
  logic               front_valid;
  logic [SUM_W-1:0]   front_sum;
  side_t              front_side;
  logic               root_valid;
  logic [ROOT_W-1:0]  root;
  side_t              root_side;
  logic [COORD_W-1:0] dist_value;

  bsd_front u_front (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .query (query),
    .valid (front_valid),
    .sum   (front_sum),
    .side  (front_side)
  );

  bsd_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (front_valid),
    .in_x     (front_sum),
    .in_side  (front_side),
    .valid    (root_valid),
    .root     (root),
    .side     (root_side)
  );

  // inside term, or outside length, saturated when too large
  always_comb begin
    if (root_side.in_box) begin
      dist_value = root_side.near;
    end else if (root_side.big || root[ROOT_W-1]) begin
      dist_value = SAT_MAX;
    end else begin
      dist_value = root[COORD_W-1:0];
    end
  end

  bsd_skid u_skid (
    .clk      (clk),
    .rst      (rst),
    .in_valid (root_valid),
    .in_data  (dist_value),
    .en       (en),
    .result   (result)
  );

  a_inside_nonpos: assert property (@(posedge clk) disable iff (rst)
    (root_valid && root_side.in_box && (root_side.near != '0)) |->
      root_side.near[COORD_W-1] && (root_side.near != {1'b1, {(COORD_W-1){1'b0}}}))
    else $error("inside distance out of range");

  a_outside_nonneg: assert property (@(posedge clk) disable iff (rst)
    (root_valid && !root_side.in_box) |-> !dist_value[COORD_W-1])
    else $error("outside distance negative");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(root_valid) && $stable(root))
    else $error("root pipeline moved during stall");

endmodule
`default_nettype wire
